FILE: hdl/pss_pkg.sv
// Shared types, register codes and coil tables for the stepper phase sequencer.
package pss_pkg;

  localparam int AXIS_COUNT_DEFAULT = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_FULL_STEP_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_AXES     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FOUR_PIN_AXES   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_PIN_AXES = 2'd3;

  localparam logic CMD_STEP   = 1'b0;
  localparam logic CMD_ENABLE = 1'b1;

  localparam logic [2:0] HALF_STEP_MASK = 3'h7;
  localparam logic [1:0] FULL_STEP_MASK = 2'h3;

  typedef logic [3:0] pins_t;
  typedef logic [2:0] step_idx_t;

  typedef struct packed {
    logic  full_step_mode;
    logic [3:0] active_axes;
    logic [3:0] four_pin_axes;
    logic [3:0] enable_pin_axes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    full_step_mode:  1'b0,
    active_axes:     4'hf,
    four_pin_axes:   4'hf,
    enable_pin_axes: 4'hf
  };

  typedef struct packed {
    step_idx_t step_index;
    pins_t     coil_levels;
    logic      enable_level;
  } axis_state_t;

  // write strobes for one axis entry
  typedef struct packed {
    logic        index_we;
    logic        coil_we;
    logic        enable_we;
    axis_state_t value;
  } axis_write_t;

  typedef struct packed {
    logic       command;
    logic [1:0] axis_number;
    logic [7:0] step_count;
    logic       direction_up;
    logic       level_on;
    logic       force_phase;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0] out_axis;
    pins_t      phase_pins;
    logic       phase_update;
    logic       enable_pin;
    logic       enable_update;
    logic       enabled_status;
  } rsp_word_t;

  function automatic pins_t half_step_4pin(input logic [2:0] idx);
    pins_t p;
    unique case (idx)
      3'd0: p = 4'd10;
      3'd1: p = 4'd8;
      3'd2: p = 4'd9;
      3'd3: p = 4'd1;
      3'd4: p = 4'd5;
      3'd5: p = 4'd4;
      3'd6: p = 4'd6;
      3'd7: p = 4'd2;
    endcase
    return p;
  endfunction

  function automatic pins_t full_step_4pin(input logic [1:0] idx);
    pins_t p;
    unique case (idx)
      2'd0: p = 4'd10;
      2'd1: p = 4'd9;
      2'd2: p = 4'd5;
      2'd3: p = 4'd6;
    endcase
    return p;
  endfunction

  function automatic pins_t full_step_2pin(input logic [1:0] idx);
    pins_t p;
    unique case (idx)
      2'd0: p = 4'd3;
      2'd1: p = 4'd2;
      2'd2: p = 4'd0;
      2'd3: p = 4'd1;
    endcase
    return p;
  endfunction

  function automatic pins_t phase_pattern(input step_idx_t idx, input logic four_pin,
                                          input logic full_step);
    pins_t p;
    if (!four_pin) begin
      p = full_step_2pin(idx[1:0] & FULL_STEP_MASK);
    end else if (full_step) begin
      p = full_step_4pin(idx[1:0] & FULL_STEP_MASK);
    end else begin
      p = half_step_4pin(idx & HALF_STEP_MASK);
    end
    return p;
  endfunction

endpackage

FILE: hdl/pss_cmd_if.sv
// Command channel: valid/ready handshake with the command word fields.
interface pss_cmd_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [1:0] axis_number;
  logic [7:0] step_count;
  logic       direction_up;
  logic       level_on;
  logic       force_phase;

  modport source (output valid, command, axis_number, step_count, direction_up, level_on,
                  force_phase, input ready);
  modport sink   (input valid, command, axis_number, step_count, direction_up, level_on,
                  force_phase, output ready);
endinterface

FILE: hdl/pss_rsp_if.sv
// Result channel: valid/ready handshake with the result word fields.
interface pss_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_axis;
  logic [3:0] phase_pins;
  logic       phase_update;
  logic       enable_pin;
  logic       enable_update;
  logic       enabled_status;

  modport source (output valid, out_axis, phase_pins, phase_update, enable_pin,
                  enable_update, enabled_status, input ready);
  modport sink   (input valid, out_axis, phase_pins, phase_update, enable_pin,
                  enable_update, enabled_status, output ready);
endinterface

FILE: hdl/pss_cfg_regs.sv
// Configuration registers: table mode and the three per-axis wiring masks.
module pss_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pss_pkg::cfg_t                  cfg
);
  import pss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FULL_STEP_MODE:  cfg.full_step_mode  <= cfg_data[0];
        REG_ACTIVE_AXES:     cfg.active_axes     <= cfg_data[3:0];
        REG_FOUR_PIN_AXES:   cfg.four_pin_axes   <= cfg_data[3:0];
        REG_ENABLE_PIN_AXES: cfg.enable_pin_axes <= cfg_data[3:0];
      endcase
    end
  end
endmodule

FILE: hdl/pss_axis_bank.sv
// Per-axis state: step index, coil levels and enable level, one entry per axis.
module pss_axis_bank #(
  parameter int AXIS_COUNT = pss_pkg::AXIS_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           axis,
  input  logic                 update,
  input  pss_pkg::axis_write_t wr,
  output pss_pkg::axis_state_t cur
);
  import pss_pkg::*;

  axis_state_t state [AXIS_COUNT];

  always_comb begin
    cur = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      if (int'(axis) == i) cur = state[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) state[i] <= '0;
    end else if (update) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        if (int'(axis) == i) begin
          if (wr.index_we)  state[i].step_index   <= wr.value.step_index;
          if (wr.coil_we)   state[i].coil_levels  <= wr.value.coil_levels;
          if (wr.enable_we) state[i].enable_level <= wr.value.enable_level;
        end
      end
    end
  end
endmodule

FILE: hdl/pss_step_logic.sv
// Command decode: new index, coil pattern, enable level and status for one word.
module pss_step_logic #(
  parameter int AXIS_COUNT = pss_pkg::AXIS_COUNT_DEFAULT
) (
  input  pss_pkg::cmd_word_t   item,
  input  pss_pkg::cfg_t        cfg,
  input  pss_pkg::axis_state_t cur,
  output pss_pkg::axis_write_t wr,
  output pss_pkg::rsp_word_t   result
);
  import pss_pkg::*;

  logic      in_range;
  logic      active;
  logic      four_pin;
  logic      has_pin;
  step_idx_t new_idx;
  pins_t     pins;
  logic      pupd;
  logic      en_after;
  pins_t     coil_after;

  assign in_range = int'(item.axis_number) < AXIS_COUNT;
  assign active   = in_range && cfg.active_axes[item.axis_number];
  assign four_pin = cfg.four_pin_axes[item.axis_number];
  assign has_pin  = cfg.enable_pin_axes[item.axis_number];
  assign new_idx  = item.direction_up ? cur.step_index + item.step_count[2:0]
                                      : cur.step_index - item.step_count[2:0];

  always_comb begin
    wr       = '0;
    wr.value = cur;
    pins     = '0;
    pupd     = 1'b0;
    result   = '0;

    if (in_range) begin
      unique case (item.command)
        CMD_STEP: begin
          // a zero count is a no-op; inactive axes still track the index
          if (item.step_count != '0) begin
            wr.index_we         = 1'b1;
            wr.value.step_index = new_idx;
            if (active) begin
              pins = phase_pattern(new_idx, four_pin, cfg.full_step_mode);
              pupd = 1'b1;
            end
          end
        end
        CMD_ENABLE: begin
          if (active) begin
            if (has_pin) begin
              wr.enable_we          = 1'b1;
              wr.value.enable_level = item.level_on;
              result.enable_pin     = item.level_on;
              result.enable_update  = 1'b1;
            end else if (four_pin) begin
              // no enable pin: off clears coils, forced on re-applies phase
              if (!item.level_on) begin
                pupd = 1'b1;
              end else if (item.force_phase) begin
                pins = phase_pattern(cur.step_index, four_pin, cfg.full_step_mode);
                pupd = 1'b1;
              end
            end
          end
        end
      endcase
    end

    if (pupd) begin
      wr.coil_we           = 1'b1;
      wr.value.coil_levels = pins;
    end

    en_after   = wr.enable_we ? item.level_on : cur.enable_level;
    coil_after = pupd ? pins : cur.coil_levels;

    result.out_axis       = item.axis_number;
    result.phase_pins     = pins;
    result.phase_update   = pupd;
    result.enabled_status = active && (has_pin ? en_after
                                               : (!four_pin || (coil_after != '0)));
  end
endmodule

FILE: hdl/stepper_phase_sequencer.sv
// Stepper phase sequencer: command channel in, one result word out per command.
//
// Usage:
//   cmd  : valid/ready channel; each word addresses one axis and is a step
//          command (move the step index by a count) or an enable command.
//   rsp  : valid/ready channel; one word per command with the coil pins and
//          enable pin written and the enable status of the axis afterwards.
//   cfg_write/cfg_index/cfg_data : register writes, taken on any clock edge;
//          write only while no command is in flight.
// Timing: a command is registered on acceptance; its result is registered as
//   it advances, which waits while rsp is held off. Axis state is updated at
//   that same edge, so while rsp is not held off a command may be accepted
//   every cycle and each sees the state left by the one before.
// Stall: when rsp is held off, the finished word waits in the output register
//   and one more command is still taken into the input register; cmd.ready
//   drops only when both are full.
// Reset (rst, synchronous): both channels empty, all step indexes, coil
//   levels and enable levels cleared, half-step mode, all axes active,
//   four-pin and with enable pin.
module stepper_phase_sequencer #(
  parameter int AXIS_COUNT = pss_pkg::AXIS_COUNT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  pss_cmd_if.sink                         cmd,
  pss_rsp_if.source                       rsp,
  input  logic                            cfg_write,
  input  logic [pss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pss_pkg::*;

  cfg_t        cfg;
  logic        held_valid;
  cmd_word_t   held;
  logic        advance;
  axis_state_t cur;
  axis_write_t wr;
  rsp_word_t   result_next;
  logic        rsp_valid;
  rsp_word_t   result;

  assign advance   = held_valid && (!rsp_valid || rsp.ready);
  assign cmd.ready = !held_valid || advance;

  pss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd.ready) begin
      held_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      held.command      <= cmd.command;
      held.axis_number  <= cmd.axis_number;
      held.step_count   <= cmd.step_count;
      held.direction_up <= cmd.direction_up;
      held.level_on     <= cmd.level_on;
      held.force_phase  <= cmd.force_phase;
    end
  end

  pss_axis_bank #(.AXIS_COUNT(AXIS_COUNT)) u_bank (
    .clk    (clk),
    .rst    (rst),
    .axis   (held.axis_number),
    .update (advance),
    .wr     (wr),
    .cur    (cur)
  );

  pss_step_logic #(.AXIS_COUNT(AXIS_COUNT)) u_logic (
    .item   (held),
    .cfg    (cfg),
    .cur    (cur),
    .wr     (wr),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= result_next;
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.out_axis       = result.out_axis;
  assign rsp.phase_pins     = result.phase_pins;
  assign rsp.phase_update   = result.phase_update;
  assign rsp.enable_pin     = result.enable_pin;
  assign rsp.enable_update  = result.enable_update;
  assign rsp.enabled_status = result.enabled_status;
endmodule

FILE: hdl/pss_checker.sv
// Port-level checks on the result channel, bound to the top level.
module pss_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] out_axis,
  input logic [3:0] phase_pins,
  input logic       phase_update,
  input logic       enable_pin,
  input logic       enable_update,
  input logic       enabled_status
);

  // a stalled word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_axis) && $stable(phase_pins)
      && $stable(enabled_status))
    else $error("result word changed while stalled");

  a_pins_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !phase_update |-> phase_pins == 4'd0)
    else $error("phase pins nonzero without phase update");

  a_enable_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !enable_update |-> !enable_pin)
    else $error("enable pin set without enable update");

  // a written enable pin is the status the axis reports
  a_enable_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && enable_update |-> enabled_status == enable_pin)
    else $error("enabled status disagrees with enable pin written");

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind stepper_phase_sequencer pss_checker u_pss_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .out_axis       (rsp.out_axis),
  .phase_pins     (rsp.phase_pins),
  .phase_update   (rsp.phase_update),
  .enable_pin     (rsp.enable_pin),
  .enable_update  (rsp.enable_update),
  .enabled_status (rsp.enabled_status)
);
